/* design/utsc_pkg.sv */
// ----------------------------------------------------------------------------
// utsc_pkg
// Shared types, rate codes and helpers for the unix time to timecode block.
// ----------------------------------------------------------------------------
`default_nettype none

package utsc_pkg;

    typedef logic [2:0] rate_t;

    localparam rate_t RATE_24    = 3'd0;
    localparam rate_t RATE_25    = 3'd1;
    localparam rate_t RATE_DF    = 3'd2;
    localparam rate_t RATE_30    = 3'd3;
    localparam rate_t RATE_50    = 3'd4;
    localparam rate_t RATE_60    = 3'd5;
    localparam rate_t RATE_RESET = RATE_30;

    // day count and second of day after the floor split, plus side data
    typedef struct packed {
        logic [22:0] days;
        logic [16:0] sod;
        logic [19:0] usec;
        rate_t       mode;
    } split_t;

    // nominal frames per second, zero for codes that mean nothing
    function automatic logic [5:0] utsc_nominal(input rate_t mode);
        logic [5:0] nom;
        unique case (mode)
            RATE_24: nom = 6'd24;
            RATE_25: nom = 6'd25;
            RATE_DF: nom = 6'd30;
            RATE_30: nom = 6'd30;
            RATE_50: nom = 6'd50;
            RATE_60: nom = 6'd60;
            default: nom = 6'd0;
        endcase
        return nom;
    endfunction

endpackage

`default_nettype wire

/* design/utsc_split.sv */
// ----------------------------------------------------------------------------
// utsc_split
// Floor split of signed seconds into a biased day count and second of day.
// ----------------------------------------------------------------------------
`default_nettype none

module utsc_split
    import utsc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               en,
    input  wire logic signed [38:0] secs,
    input  wire logic        [19:0] usec,
    input  wire rate_t              mode,
    output split_t                  o
);

    // bias by 22 eras of days so everything below is unsigned; the era
    // bias is a multiple of 400 years and drops out of the year mod 100
    localparam longint unsigned OFF_SEC = 64'd277701177600;
    localparam int              SH_DAY  = 40;
    localparam longint unsigned M_DAY   = 64'd3257812230;   // floor(2^48 / 86400)

    logic [39:0] su_reg, su2_reg;
    logic [63:0] prod_reg;
    logic [22:0] dest_reg, days_reg;
    logic [17:0] r_reg;
    logic [16:0] sod_reg;
    logic [19:0] usec_p_reg [1:4];
    rate_t       mode_p_reg [1:4];

    logic [39:0] su_next;
    logic [63:0] prod_next;
    logic [22:0] dest_next, days_next;
    logic [39:0] r_full;
    logic [17:0] r_next;
    logic [16:0] sod_next;

    always_comb begin
        su_next   = {secs[38], secs} + 40'(OFF_SEC);
        prod_next = 64'(su_reg[39:8]) * 64'(M_DAY);
        // estimate is the quotient or one below it
        dest_next = 23'(prod_reg >> SH_DAY);
        r_full    = su2_reg - 40'(dest_next) * 40'd86400;
        r_next    = r_full[17:0];
        if (r_reg >= 18'd86400) begin
            days_next = dest_reg + 23'd1;
            sod_next  = 17'(r_reg - 18'd86400);
        end else begin
            days_next = dest_reg;
            sod_next  = r_reg[16:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            su_reg        <= su_next;
            prod_reg      <= prod_next;
            su2_reg       <= su_reg;
            dest_reg      <= dest_next;
            r_reg         <= r_next;
            days_reg      <= days_next;
            sod_reg       <= sod_next;
            usec_p_reg[1] <= usec;
            mode_p_reg[1] <= mode;
            for (int i = 2; i <= 4; i++) begin
                usec_p_reg[i] <= usec_p_reg[i-1];
                mode_p_reg[i] <= mode_p_reg[i-1];
            end
        end
    end

    assign o = '{days: days_reg, sod: sod_reg, usec: usec_p_reg[4], mode: mode_p_reg[4]};

endmodule

`default_nettype wire

/* design/utsc_date.sv */
// ----------------------------------------------------------------------------
// utsc_date
// Days to civil date pipeline: year mod 100, month and day of month.
// ----------------------------------------------------------------------------
`default_nettype none

module utsc_date
    import utsc_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   en,
    input  wire split_t in,
    output logic [6:0]  year_of_century,
    output logic [3:0]  month_number,
    output logic [4:0]  day_of_month
);

    localparam int SH_ERA = 40;
    localparam longint unsigned M_ERA = 64'd7525836;       // below 2^40 / 146097, so the era estimate never overshoots
    localparam int SH_1460 = 29;
    localparam longint unsigned M_1460 = ((64'd1 << SH_1460) + 64'd1459) / 64'd1460;
    localparam int SH_36524 = 34;
    localparam longint unsigned M_36524 = ((64'd1 << SH_36524) + 64'd36523) / 64'd36524;
    localparam int SH_146096 = 36;
    localparam longint unsigned M_146096 = ((64'd1 << SH_146096) + 64'd146095) / 64'd146096;
    localparam int SH_365 = 27;
    localparam longint unsigned M_365 = ((64'd1 << SH_365) + 64'd364) / 64'd365;
    localparam int SH_100 = 16;
    localparam longint unsigned M_100 = ((64'd1 << SH_100) + 64'd99) / 64'd100;
    localparam int SH_153 = 19;
    localparam longint unsigned M_153 = ((64'd1 << SH_153) + 64'd152) / 64'd153;
    localparam int SH_5 = 14;
    localparam longint unsigned M_5 = ((64'd1 << SH_5) + 64'd4) / 64'd5;

    logic [22:0] z_p_reg [1:2];
    logic [63:0] ep_reg;
    logic [18:0] dr_reg;
    logic [17:0] doe_p_reg [4:8];
    logic [10:0] q1_reg;
    logic [2:0]  q2_reg;
    logic        q3_reg;
    logic [17:0] a_reg;
    logic [8:0]  yoe_p_reg [7:8];
    logic [2:0]  yq_reg;
    logic [17:0] y365_reg;
    logic [8:0]  doy_p_reg [9:11];
    logic [6:0]  ym_p_reg [9:11];
    logic [3:0]  mp_p_reg [10:11];
    logic [10:0] t_reg;
    logic [6:0]  yc_reg, ycent_reg;
    logic [3:0]  mo_reg, mo13_reg;
    logic [4:0]  dy_reg, dy13_reg;

    logic [5:0]  eest;
    logic [22:0] dr_full;
    logic [18:0] doe_full;
    logic [10:0] q1_next;
    logic [2:0]  q2_next;
    logic        q3_next;
    logic [17:0] a_next;
    logic [8:0]  yoe_next;
    logic [2:0]  yq_next;
    logic [17:0] y365_next;
    logic [17:0] doy_full;
    logic [6:0]  ym_next;
    logic [10:0] v5;
    logic [3:0]  mp_next;
    logic [10:0] t_next;
    logic [9:0]  dq_wide;
    logic [4:0]  dy_next;
    logic [3:0]  mo_next;
    logic [6:0]  yc_next, ycent_next;

    always_comb begin
        eest     = 6'(ep_reg >> SH_ERA);
        dr_full  = z_p_reg[2] - 23'(eest) * 23'd146097;
        doe_full = (dr_reg >= 19'd146097) ? dr_reg - 19'd146097 : dr_reg;
        q1_next  = 11'((64'(doe_p_reg[4]) * 64'(M_1460)) >> SH_1460);
        q2_next  = 3'((64'(doe_p_reg[4]) * 64'(M_36524)) >> SH_36524);
        q3_next  = 1'((64'(doe_p_reg[4]) * 64'(M_146096)) >> SH_146096);
        a_next   = doe_p_reg[5] - 18'(q1_reg) + 18'(q2_reg) - 18'(q3_reg);
        yoe_next = 9'((64'(a_reg) * 64'(M_365)) >> SH_365);
        yq_next  = 3'((64'(yoe_p_reg[7]) * 64'(M_100)) >> SH_100);
        y365_next = 18'(yoe_p_reg[7]) * 18'd365;
        doy_full = doe_p_reg[8] - (y365_reg + 18'(yoe_p_reg[8][8:2]) - 18'(yq_reg));
        ym_next  = 7'(yoe_p_reg[8] - 9'(yq_reg) * 9'd100);
        v5       = (11'(doy_p_reg[9]) << 2) + 11'(doy_p_reg[9]) + 11'd2;
        mp_next  = 4'((64'(v5) * 64'(M_153)) >> SH_153);
        t_next   = 11'(mp_p_reg[10]) * 11'd153 + 11'd2;
        dq_wide  = 10'((64'(t_reg) * 64'(M_5)) >> SH_5);
        dy_next  = 5'(10'(doy_p_reg[11]) - dq_wide + 10'd1);
        mo_next  = (mp_p_reg[11] < 4'd10) ? mp_p_reg[11] + 4'd3 : mp_p_reg[11] - 4'd9;
        // january and february belong to the next year
        yc_next  = ym_p_reg[11] + 7'((mp_p_reg[11] >= 4'd10) ? 1 : 0);
        ycent_next = (yc_reg == 7'd100) ? 7'd0 : yc_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            z_p_reg[1]   <= in.days + 23'd719468;
            z_p_reg[2]   <= z_p_reg[1];
            ep_reg       <= 64'(z_p_reg[1]) * 64'(M_ERA);
            dr_reg       <= dr_full[18:0];
            doe_p_reg[4] <= doe_full[17:0];
            for (int i = 5; i <= 8; i++) begin
                doe_p_reg[i] <= doe_p_reg[i-1];
            end
            q1_reg       <= q1_next;
            q2_reg       <= q2_next;
            q3_reg       <= q3_next;
            a_reg        <= a_next;
            yoe_p_reg[7] <= yoe_next;
            yoe_p_reg[8] <= yoe_p_reg[7];
            yq_reg       <= yq_next;
            y365_reg     <= y365_next;
            doy_p_reg[9] <= doy_full[8:0];
            ym_p_reg[9]  <= ym_next;
            for (int i = 10; i <= 11; i++) begin
                doy_p_reg[i] <= doy_p_reg[i-1];
                ym_p_reg[i]  <= ym_p_reg[i-1];
            end
            mp_p_reg[10] <= mp_next;
            mp_p_reg[11] <= mp_p_reg[10];
            t_reg        <= t_next;
            dy_reg       <= dy_next;
            mo_reg       <= mo_next;
            yc_reg       <= yc_next;
            ycent_reg    <= ycent_next;
            mo13_reg     <= mo_reg;
            dy13_reg     <= dy_reg;
        end
    end

    assign year_of_century = ycent_reg;
    assign month_number    = mo13_reg;
    assign day_of_month    = dy13_reg;

endmodule

`default_nettype wire

/* design/utsc_tod.sv */
// ----------------------------------------------------------------------------
// utsc_tod
// Time of day pipeline: hours, minutes, seconds and frame label, with
// drop-frame renumbering for the 29.97 rate.
// ----------------------------------------------------------------------------
`default_nettype none

module utsc_tod
    import utsc_pkg::*;
(
    input  wire logic   aclk,
    input  wire logic   en,
    input  wire split_t in,
    output logic        ok,
    output logic        df_mode,
    output logic [4:0]  hours,
    output logic [5:0]  minutes,
    output logic [5:0]  seconds_field,
    output logic [5:0]  frame_number
);

    localparam int SH_US = 30;
    localparam longint unsigned M_US = ((64'd1 << SH_US) + 64'd999) / 64'd1000;
    localparam int SH_MEG = 46;
    localparam longint unsigned M_MEG = ((64'd1 << SH_MEG) + 64'd999999) / 64'd1000000;
    localparam int SH_NTSC = 42;
    localparam longint unsigned M_NTSC = ((64'd1 << SH_NTSC) + 64'd1000) / 64'd1001;
    localparam int SH_BLK = 37;
    localparam longint unsigned M_BLK = ((64'd1 << SH_BLK) + 64'd17981) / 64'd17982;
    localparam int SH_MIN = 26;
    localparam longint unsigned M_MIN = ((64'd1 << SH_MIN) + 64'd1797) / 64'd1798;
    localparam int SH_F30 = 27;
    localparam longint unsigned M_F30 = ((64'd1 << SH_F30) + 64'd29) / 64'd30;
    localparam int SH_S60 = 23;
    localparam longint unsigned M_S60 = ((64'd1 << SH_S60) + 64'd59) / 64'd60;
    localparam int SH_M60 = 17;
    localparam longint unsigned M_M60 = ((64'd1 << SH_M60) + 64'd59) / 64'd60;

    rate_t       mode_p_reg [1:12];
    logic [16:0] sod_p_reg [1:9];
    logic [5:0]  fq_p_reg [2:10];
    logic [21:0] tot_p_reg [4:8];
    logic [7:0]  blk_p_reg [5:8];
    logic [21:0] t2_p_reg [9:10];
    logic [16:0] s_p_reg [10:11];
    logic [10:0] mq_p_reg [11:12];
    logic [5:0]  ff_p_reg [11:12];
    logic [26:0] s1000_reg, ms_reg;
    logic [10:0] uq_reg;
    logic [25:0] fp_reg;
    logic [31:0] n_reg;
    logic [14:0] rem_reg, rm2_reg;
    logic [3:0]  q_reg;
    logic [16:0] sd_reg;
    logic [5:0]  ss_reg;
    logic [4:0]  hq_reg;
    logic        ok_reg, drop_reg;
    logic [4:0]  hh_reg;
    logic [5:0]  mm_reg, ss13_reg, ff13_reg;

    logic [5:0]  nom_in, nom10;
    logic [64:0] tot_prod;
    logic [21:0] rem_full, t2_next;
    logic [16:0] sd_next, s_next;
    logic [21:0] ffd_full;
    logic [5:0]  ff_next;
    logic [16:0] ss_full;
    logic [10:0] mm_full;
    logic [4:0]  hh_next;
    logic        ok12, drop12;

    always_comb begin
        nom_in   = utsc_nominal(in.mode);
        tot_prod = 65'(n_reg) * 65'(M_NTSC);
        rem_full = tot_p_reg[5] - 22'(blk_p_reg[5]) * 22'd17982;
        t2_next  = tot_p_reg[8] + 22'(blk_p_reg[8]) * 22'd18 + 22'({q_reg, 1'b0});
        sd_next  = 17'((64'(t2_p_reg[9]) * 64'(M_F30)) >> SH_F30);
        s_next   = (mode_p_reg[9] == RATE_DF) ? sd_next : sod_p_reg[9];
        nom10    = utsc_nominal(mode_p_reg[10]);
        ffd_full = t2_p_reg[10] - 22'(sd_reg) * 22'd30;
        if (mode_p_reg[10] == RATE_DF) begin
            ff_next = 6'(ffd_full[4:0]);
        end else if (fq_p_reg[10] >= nom10) begin
            ff_next = nom10 - 6'd1;
        end else begin
            ff_next = fq_p_reg[10];
        end
        ss_full  = s_p_reg[11] - 17'(mq_p_reg[11]) * 17'd60;
        mm_full  = mq_p_reg[12] - 11'(hq_reg) * 11'd60;
        hh_next  = (hq_reg >= 5'd24) ? hq_reg - 5'd24 : hq_reg;
        ok12     = (utsc_nominal(mode_p_reg[12]) != 6'd0);
        drop12   = (mode_p_reg[12] == RATE_DF);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 1: milliseconds parts and the plain frame product
            s1000_reg     <= 27'(32'(in.sod) * 32'd1000);
            uq_reg        <= 11'((64'(in.usec) * 64'(M_US)) >> SH_US);
            fp_reg        <= 26'(32'(in.usec) * 32'(nom_in));
            mode_p_reg[1] <= in.mode;
            sod_p_reg[1]  <= in.sod;
            for (int i = 2; i <= 12; i++) begin
                mode_p_reg[i] <= mode_p_reg[i-1];
            end
            for (int i = 2; i <= 9; i++) begin
                sod_p_reg[i] <= sod_p_reg[i-1];
            end
            // stage 2
            ms_reg      <= s1000_reg + 27'(uq_reg);
            fq_p_reg[2] <= 6'((64'(fp_reg) * 64'(M_MEG)) >> SH_MEG);
            for (int i = 3; i <= 10; i++) begin
                fq_p_reg[i] <= fq_p_reg[i-1];
            end
            // stage 3..4: frame periods since midnight
            n_reg        <= (32'(ms_reg) << 5) - (32'(ms_reg) << 1);
            tot_p_reg[4] <= 22'(tot_prod >> SH_NTSC);
            for (int i = 5; i <= 8; i++) begin
                tot_p_reg[i] <= tot_p_reg[i-1];
            end
            // stage 5..9: ten minute blocks and dropped labels
            blk_p_reg[5] <= 8'((64'(tot_p_reg[4]) * 64'(M_BLK)) >> SH_BLK);
            for (int i = 6; i <= 8; i++) begin
                blk_p_reg[i] <= blk_p_reg[i-1];
            end
            rem_reg      <= rem_full[14:0];
            rm2_reg      <= (rem_reg < 15'd2) ? 15'd0 : rem_reg - 15'd2;
            q_reg        <= 4'((64'(rm2_reg) * 64'(M_MIN)) >> SH_MIN);
            t2_p_reg[9]  <= t2_next;
            t2_p_reg[10] <= t2_p_reg[9];
            // stage 10..13: seconds count split into fields
            sd_reg       <= sd_next;
            s_p_reg[10]  <= s_next;
            s_p_reg[11]  <= s_p_reg[10];
            ff_p_reg[11] <= ff_next;
            ff_p_reg[12] <= ff_p_reg[11];
            mq_p_reg[11] <= 11'((64'(s_p_reg[10]) * 64'(M_S60)) >> SH_S60);
            mq_p_reg[12] <= mq_p_reg[11];
            ss_reg       <= ss_full[5:0];
            hq_reg       <= 5'((64'(mq_p_reg[11]) * 64'(M_M60)) >> SH_M60);
            ok_reg       <= ok12;
            drop_reg     <= drop12;
            hh_reg       <= ok12 ? hh_next : 5'd0;
            mm_reg       <= ok12 ? mm_full[5:0] : 6'd0;
            ss13_reg     <= ok12 ? ss_reg : 6'd0;
            ff13_reg     <= ok12 ? ff_p_reg[12] : 6'd0;
        end
    end

    assign ok            = ok_reg;
    assign df_mode       = drop_reg;
    assign hours         = hh_reg;
    assign minutes       = mm_reg;
    assign seconds_field = ss13_reg;
    assign frame_number  = ff13_reg;

endmodule

`default_nettype wire

/* design/unix_time_to_smpte_timecode.sv */
// path: an accepted word runs through the split, date and time of day
// pipelines; a word taken during a stall waits in the skid register
// throughput: one word per cycle; a stalled result holds the whole pipeline
// reset: synchronous active-low aresetn clears valid bits and the skid
// register, and sets the frame rate mode to 30 fps
// ----------------------------------------------------------------------------
// unix_time_to_smpte_timecode
// Unix seconds plus microseconds to civil date and SMPTE timecode.
// ----------------------------------------------------------------------------
`default_nettype none

module unix_time_to_smpte_timecode
    import utsc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [2:0]         cfg_data,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [38:0] s_epoch_seconds,
    input  wire logic        [19:0] s_micro_seconds,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic                    m_ok,
    output logic                    m_df_mode,
    output logic [6:0]              m_year_of_century,
    output logic [3:0]              m_month_number,
    output logic [4:0]              m_day_of_month,
    output logic [4:0]              m_hours,
    output logic [5:0]              m_minutes,
    output logic [5:0]              m_seconds_field,
    output logic [5:0]              m_frame_number
);

    localparam int LAT = 17;

    rate_t              mode_reg;
    logic               skid_valid_reg;
    logic signed [38:0] skid_secs_reg;
    logic        [19:0] skid_usec_reg;
    logic [LAT-1:0]     vld_reg;

    logic               adv;
    logic               head_valid;
    logic signed [38:0] head_secs;
    logic        [19:0] head_usec;
    split_t             split_o;

    assign cfg_ready  = 1'b1;
    assign s_ready    = !skid_valid_reg;
    assign adv        = !vld_reg[LAT-1] || m_ready;
    assign head_valid = skid_valid_reg || s_valid;
    assign head_secs  = skid_valid_reg ? skid_secs_reg : s_epoch_seconds;
    assign head_usec  = skid_valid_reg ? skid_usec_reg : s_micro_seconds;
    assign m_valid    = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= RATE_RESET;
        end else if (cfg_valid) begin
            mode_reg <= cfg_data;
        end
    end

    // skid word catches the input while the pipeline is held
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else if (adv) begin
            skid_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!adv && s_valid && !skid_valid_reg) begin
            skid_secs_reg <= s_epoch_seconds;
            skid_usec_reg <= s_micro_seconds;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[LAT-2:0], head_valid};
        end
    end

    utsc_split u_split (
        .aclk (aclk),
        .en   (adv),
        .secs (head_secs),
        .usec (head_usec),
        .mode (mode_reg),
        .o    (split_o)
    );

    utsc_date u_date (
        .aclk            (aclk),
        .en              (adv),
        .in              (split_o),
        .year_of_century (m_year_of_century),
        .month_number    (m_month_number),
        .day_of_month    (m_day_of_month)
    );

    utsc_tod u_tod (
        .aclk          (aclk),
        .en            (adv),
        .in            (split_o),
        .ok            (m_ok),
        .df_mode       (m_df_mode),
        .hours         (m_hours),
        .minutes       (m_minutes),
        .seconds_field (m_seconds_field),
        .frame_number  (m_frame_number)
    );

    a_accept_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (vld_reg[0] || skid_valid_reg))
        else $error("accepted word neither entered the pipeline nor the skid");

    a_date_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_month_number >= 4'd1 && m_month_number <= 4'd12 &&
                     m_day_of_month >= 5'd1 && m_year_of_century <= 7'd99))
        else $error("civil date out of range");

    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ok) |-> (m_hours <= 5'd23 && m_minutes <= 6'd59 &&
                               m_seconds_field <= 6'd59 && m_frame_number <= 6'd59))
        else $error("timecode out of range");

    a_bad_rate_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ok) |-> (m_hours == 5'd0 && m_minutes == 6'd0 &&
                                m_seconds_field == 6'd0 && m_frame_number == 6'd0 &&
                                !m_df_mode))
        else $error("time fields not cleared for invalid rate");

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the unix time to timecode block: a directed table
// followed by random timestamps under every rate code, with random stalls on
// both channels, checked word by word against an in-bench date and timecode
// calculator.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import utsc_pkg::*;

    localparam rate_t RATE_BAD6 = 3'd6;
    localparam rate_t RATE_BAD7 = 3'd7;
    localparam int    N_DIR     = 22;
    localparam int    PHASE_LEN = 200;

    typedef struct packed {
        logic       ok;
        logic       df;
        logic [6:0] yoc;
        logic [3:0] mo;
        logic [4:0] dy;
        logic [4:0] hh;
        logic [5:0] mm;
        logic [5:0] ss;
        logic [5:0] ff;
    } tc_t;

    typedef struct packed {
        rate_t              mode;
        logic signed [38:0] ep;
        logic [19:0]        us;
        logic               known;
        tc_t                want;
    } row_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [38:0] s_epoch_seconds = '0;
    logic [19:0]        s_micro_seconds = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_ok, m_df_mode;
    logic [6:0]         m_year_of_century;
    logic [3:0]         m_month_number;
    logic [4:0]         m_day_of_month, m_hours;
    logic [5:0]         m_minutes, m_seconds_field, m_frame_number;

    tc_t   timecode_q[$];
    rate_t rate_now = RATE_RESET;
    int    errors = 0;
    int    words_in = 0;
    int    words_out = 0;
    bit    hold_req = 0;
    bit    tx_burst = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    unix_time_to_smpte_timecode dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_epoch_seconds(s_epoch_seconds), .s_micro_seconds(s_micro_seconds),
        .m_valid(m_valid), .m_ready(m_ready), .m_ok(m_ok),
        .m_df_mode(m_df_mode), .m_year_of_century(m_year_of_century),
        .m_month_number(m_month_number), .m_day_of_month(m_day_of_month),
        .m_hours(m_hours), .m_minutes(m_minutes),
        .m_seconds_field(m_seconds_field), .m_frame_number(m_frame_number)
    );

    function automatic longint floor_div(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) q--;
        return q;
    endfunction

    // civil date plus timecode for one timestamp
    function automatic tc_t timecode_of(input logic signed [38:0] ep,
                                        input logic [19:0] us, input rate_t mode);
        tc_t    r;
        longint secs, days, sod, z, era, doe, yoe, doy, mp, y, d, m, yc;
        longint nom, ms, total, blocks, rem;
        r = '0;
        secs = ep;
        days = floor_div(secs, 86400);
        sod = secs - days * 86400;
        z = days + 719468;
        era = floor_div(z, 146097);
        doe = z - era * 146097;
        yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp = (5 * doy + 2) / 153;
        y = yoe + era * 400;
        d = doy - (153 * mp + 2) / 5 + 1;
        m = (mp < 10) ? mp + 3 : mp - 9;
        if (m <= 2) y++;
        yc = y % 100;
        if (yc < 0) yc += 100;
        r.yoc = yc[6:0];
        r.mo = m[3:0];
        r.dy = d[4:0];
        r.df = (mode == RATE_DF);
        case (mode)
            RATE_24: nom = 24;
            RATE_25: nom = 25;
            RATE_DF: nom = 30;
            RATE_30: nom = 30;
            RATE_50: nom = 50;
            RATE_60: nom = 60;
            default: nom = 0;
        endcase
        r.ok = (nom != 0);
        if (mode == RATE_DF) begin
            ms = sod * 1000 + longint'(us) / 1000;
            total = (ms * 30000) / 1001000;
            blocks = total / 17982;
            rem = total % 17982;
            if (rem < 2) rem = 2;
            total += 18 * blocks + 2 * ((rem - 2) / 1798);
            r.ff = 6'(total % 30);
            r.ss = 6'((total / 30) % 60);
            r.mm = 6'((total / 1800) % 60);
            r.hh = 5'((total / 108000) % 24);
        end else if (nom != 0) begin
            ms = (longint'(us) * nom) / 1000000;
            if (ms >= nom) ms = nom - 1;
            r.ff = ms[5:0];
            r.hh = 5'(sod / 3600);
            r.mm = 6'((sod % 3600) / 60);
            r.ss = 6'(sod % 60);
        end
        return r;
    endfunction

    task automatic report(input string what, input int got, input int want);
        errors++;
        $display("mismatch word %0d %s: got %0d want %0d", words_out, what, got, want);
    endtask

    // result side: random stalls, one long hold on request
    initial begin : result_side
        int  stall;
        int  hold;
        bit  burst;
        tc_t want;
        stall = 0;
        hold = 0;
        burst = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                if (timecode_q.size() == 0) begin
                    report("unexpected result word", 1, 0);
                end else begin
                    want = timecode_q.pop_front();
                    if (m_ok !== want.ok) report("ok", m_ok, want.ok);
                    if (m_df_mode !== want.df) report("df_mode", m_df_mode, want.df);
                    if (m_year_of_century !== want.yoc)
                        report("year", m_year_of_century, want.yoc);
                    if (m_month_number !== want.mo) report("month", m_month_number, want.mo);
                    if (m_day_of_month !== want.dy) report("day", m_day_of_month, want.dy);
                    if (m_hours !== want.hh) report("hours", m_hours, want.hh);
                    if (m_minutes !== want.mm) report("minutes", m_minutes, want.mm);
                    if (m_seconds_field !== want.ss)
                        report("seconds", m_seconds_field, want.ss);
                    if (m_frame_number !== want.ff) report("frame", m_frame_number, want.ff);
                end
                words_out++;
                if ($urandom_range(0, 30) == 0) burst = !burst;
                stall = burst ? 0 : $urandom_range(0, 15);
            end
            if (hold_req && hold == 0) begin
                hold = 400;
                hold_req = 0;
            end
            if (hold > 0) begin
                hold--;
                m_ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // called at a clock edge; returns at the edge the word is taken
    task automatic send_word(input logic signed [38:0] ep, input logic [19:0] us);
        int gap;
        if ($urandom_range(0, 30) == 0) tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_epoch_seconds <= ep;
        s_micro_seconds <= us;
        do @(posedge aclk); while (!s_ready);
        timecode_q.push_back(timecode_of(ep, us, rate_now));
        words_in++;
    endtask

    task automatic push_known(input logic signed [38:0] ep, input logic [19:0] us,
                              input tc_t want);
        send_word(ep, us);
        void'(timecode_q.pop_back());
        timecode_q.push_back(want);
    endtask

    // drain, let the pipeline empty, then write the rate code
    task automatic set_rate(input rate_t mode);
        s_valid <= 1'b0;
        while (timecode_q.size() != 0) @(posedge aclk);
        repeat (24) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= mode;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        rate_now = mode;
    endtask

    function automatic logic signed [38:0] rand_epoch();
        longint v;
        case ($urandom_range(0, 3))
            0: v = longint'({$urandom_range(0, 127), $urandom}) - (longint'(1) << 38);
            1: v = -62135596800 + longint'({$urandom, $urandom} % 64'd315537897600);
            // around midnight
            2: v = (longint'($urandom_range(0, 3652058)) - 719162) * 86400
                   + $urandom_range(0, 3) - 2;
            // around a minute boundary, ten-minute ones included
            default: v = (longint'($urandom_range(0, 3652058)) - 719162) * 86400
                         + longint'($urandom_range(0, 1439)) * 60
                         + $urandom_range(0, 3) - 1;
        endcase
        return v[38:0];
    endfunction

    function automatic logic [19:0] rand_usec();
        case ($urandom_range(0, 7))
            0: return 20'($urandom_range(999000, 1048575));
            1: return 20'($urandom_range(0, 2000));
            default: return 20'($urandom_range(0, 999999));
        endcase
    endfunction

    initial begin : stimulus
        row_t  rows [N_DIR];
        rate_t plan [9];
        rows = '{
            '{RATE_30, 39'sd0, 20'd0, 1'b1, '{1, 0, 70, 1, 1, 0, 0, 0, 0}},
            '{RATE_30, -39'sd62135596800, 20'd0, 1'b1, '{1, 0, 1, 1, 1, 0, 0, 0, 0}},
            '{RATE_30, 39'sd253402300799, 20'd999999, 1'b1,
              '{1, 0, 99, 12, 31, 23, 59, 59, 29}},
            '{RATE_30, -39'sd1, 20'd0, 1'b1, '{1, 0, 69, 12, 31, 23, 59, 59, 0}},
            '{RATE_30, 39'sd274877906943, 20'd0, 1'b0, '0},
            '{RATE_30, -39'sd274877906944, 20'd0, 1'b0, '0},
            '{RATE_30, 39'sd951782400, 20'd500000, 1'b0, '0},
            '{RATE_30, 39'sd0, 20'd1048575, 1'b0, '0},
            '{RATE_24, 39'sd0, 20'd999999, 1'b1, '{1, 0, 70, 1, 1, 0, 0, 0, 23}},
            '{RATE_25, 39'sd86399, 20'd500000, 1'b0, '0},
            '{RATE_50, 39'sd0, 20'd999999, 1'b1, '{1, 0, 70, 1, 1, 0, 0, 0, 49}},
            '{RATE_60, 39'sd0, 20'd999999, 1'b1, '{1, 0, 70, 1, 1, 0, 0, 0, 59}},
            '{RATE_DF, 39'sd0, 20'd0, 1'b1, '{1, 1, 70, 1, 1, 0, 0, 0, 0}},
            '{RATE_DF, 39'sd60, 20'd0, 1'b0, '0},
            '{RATE_DF, 39'sd599, 20'd999999, 1'b0, '0},
            '{RATE_DF, 39'sd600, 20'd0, 1'b0, '0},
            '{RATE_DF, 39'sd3599, 20'd500000, 1'b0, '0},
            '{RATE_DF, 39'sd86399, 20'd999999, 1'b0, '0},
            '{RATE_DF, 39'sd86399, 20'd1048575, 1'b0, '0},
            '{RATE_DF, -39'sd1, 20'd0, 1'b0, '0},
            '{RATE_BAD6, 39'sd0, 20'd0, 1'b1, '{0, 0, 70, 1, 1, 0, 0, 0, 0}},
            '{RATE_BAD7, 39'sd253402300799, 20'd999999, 1'b1,
              '{0, 0, 99, 12, 31, 0, 0, 0, 0}}
        };
        plan = '{RATE_DF, RATE_24, RATE_BAD6, RATE_60, RATE_25, RATE_DF,
                 RATE_50, RATE_BAD7, RATE_30};
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int i = 0; i < N_DIR; i++) begin
            if (rows[i].mode != rate_now) set_rate(rows[i].mode);
            if (rows[i].known) push_known(rows[i].ep, rows[i].us, rows[i].want);
            else send_word(rows[i].ep, rows[i].us);
        end
        for (int p = 0; p < 9; p++) begin
            set_rate(plan[p]);
            // first random phase: long result-side hold while words keep coming
            if (p == 0) hold_req = 1;
            for (int k = 0; k < PHASE_LEN; k++) send_word(rand_epoch(), rand_usec());
        end
        s_valid <= 1'b0;
        while (timecode_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        $display("sent %0d words, %0d results checked, all eight rate codes", words_in,
                 words_out);
        $display("covered: date extremes, full 39-bit range, drop-frame minute edges");
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #20000000;
        $display("timeout");
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire
